/* rtl/pij_pkg.sv */
// ----------------------------------------------------------------------------
// pij_pkg
// shared widths, constants and types of the point image jacobian
// ----------------------------------------------------------------------------
package pij_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned DEPTH_W = 24;
	localparam int unsigned FOCAL_W = 16;
	localparam int unsigned OUT_W   = 48;
	localparam int unsigned QUO_W   = 46;
	localparam int unsigned ZSH     = 28;
	localparam int unsigned LSH     = 12;

	localparam logic [FOCAL_W-1:0] FOCAL_RST = 16'd8498;
	localparam logic [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
		logic                      zz;
	} side_t;

endpackage

/* rtl/pij_div.sv */
// ----------------------------------------------------------------------------
// pij_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module pij_div
	import pij_pkg::*;
#(
	parameter int unsigned NUM_W = QUO_W,
	parameter int unsigned DEN_W = DEPTH_W
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q [0:NUM_W];
	logic [NUM_W-1:0] nq_q  [0:NUM_W];
	logic [DEN_W-1:0] den_q [0:NUM_W];

	assign rem_q[0] = '0;
	assign nq_q[0]  = num;
	assign den_q[0] = den;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] t;
		logic [DEN_W:0] d;
		logic           ge;
		always_comb begin
			t  = {rem_q[i], nq_q[i][NUM_W-1]};
			d  = t - {1'b0, den_q[i]};
			ge = t >= {1'b0, den_q[i]};
		end
		always_ff @(posedge clk) begin
			rem_q[i+1] <= ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
			nq_q[i+1]  <= {nq_q[i][NUM_W-2:0], ge};
			den_q[i+1] <= den_q[i];
		end
	end

	assign quo = nq_q[NUM_W];

endmodule

/* rtl/point_image_jacobian.sv */
// ----------------------------------------------------------------------------
// point_image_jacobian
// interaction matrix entries of one image point feature
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// command   in   start / busy     u_coord, v_coord, depth
// result    out  done strobe      ten matrix entries, depth_zero
// config    in   cfg_we           cfg_data (focal length)
//
// a word is taken every cycle; busy is always low
// result passes through three input stages,
// a 46 stage divider (one quotient bit per stage) and an output register
// no stall on either side; reset clears valid bits and loads the default
// focal length
// ----------------------------------------------------------------------------
module point_image_jacobian
	import pij_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] u_coord,
	input  logic signed [COORD_W-1:0] v_coord,
	input  logic [DEPTH_W-1:0]        depth,
	input  logic                      cfg_we,
	input  logic [FOCAL_W-1:0]        cfg_data,
	output logic                      done,
	output logic signed [OUT_W-1:0]   x_trans_x,
	output logic signed [OUT_W-1:0]   x_trans_z,
	output logic signed [OUT_W-1:0]   x_rot_x,
	output logic signed [OUT_W-1:0]   x_rot_y,
	output logic signed [OUT_W-1:0]   x_rot_z,
	output logic signed [OUT_W-1:0]   y_trans_y,
	output logic signed [OUT_W-1:0]   y_trans_z,
	output logic signed [OUT_W-1:0]   y_rot_x,
	output logic signed [OUT_W-1:0]   y_rot_y,
	output logic signed [OUT_W-1:0]   y_rot_z,
	output logic                      depth_zero
);

	localparam int unsigned LAT = QUO_W + 4;

	logic [FOCAL_W-1:0] focal_q;

	logic                      vld_s1, vld_s2, vld_s3;
	logic signed [COORD_W-1:0] u_s1, v_s1, u_s2, v_s2;
	logic [DEPTH_W-1:0]        z_s1, z_s2;
	logic [FOCAL_W-1:0]        lam_s1, lam_s2;
	logic [2*COORD_W-1:0]      uu_s2, vv_s2;
	logic signed [2*COORD_W-1:0] uv_s2;
	logic [2*FOCAL_W-1:0]      lam2_s2;

	logic [QUO_W-1:0]   num_lz_s3, num_uz_s3, num_vz_s3;
	logic [QUO_W-1:0]   num_uv_s3, num_ru_s3, num_rv_s3;
	logic [DEPTH_W-1:0] den_z_s3, den_l_s3;
	side_t              side_s3;

	logic  vld_q  [0:QUO_W-1];
	side_t side_q [0:QUO_W-1];

	logic [QUO_W-1:0] q_lz, q_uz, q_vz, q_uv, q_ru, q_rv;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RST;
		end else if (cfg_we) begin
			focal_q <= cfg_data;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int i = 0; i < QUO_W; i++) vld_q[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1   <= start & ~busy;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_q[0] <= vld_s3;
			for (int i = 1; i < QUO_W; i++) vld_q[i] <= vld_q[i-1];
			done <= vld_q[QUO_W-1];
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		u_s1   <= u_coord;
		v_s1   <= v_coord;
		z_s1   <= depth;
		lam_s1 <= focal_q;
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		u_s2    <= u_s1;
		v_s2    <= v_s1;
		z_s2    <= z_s1;
		lam_s2  <= lam_s1;
		uu_s2   <= 32'(u_s1 * u_s1);
		vv_s2   <= 32'(v_s1 * v_s1);
		uv_s2   <= u_s1 * v_s1;
		lam2_s2 <= lam_s1 * lam_s1;
	end

	// stage 3: rounded numerators
	logic [COORD_W-1:0]   au, av;
	logic [2*COORD_W-1:0] auv;
	logic [DEPTH_W-1:0]   lden;
	always_comb begin
		au   = u_s2[COORD_W-1] ? COORD_W'(-u_s2) : u_s2;
		av   = v_s2[COORD_W-1] ? COORD_W'(-v_s2) : v_s2;
		auv  = uv_s2[2*COORD_W-1] ? 32'(-uv_s2) : uv_s2;
		lden = (lam_s2 == '0) ? DEPTH_W'(1) : DEPTH_W'(lam_s2);
	end

	always_ff @(posedge clk) begin
		den_z_s3  <= (z_s2 == '0) ? DEPTH_W'(1) : z_s2;
		den_l_s3  <= lden;
		num_lz_s3 <= (QUO_W'(lam_s2) << ZSH) + QUO_W'(z_s2 >> 1);
		num_uz_s3 <= (QUO_W'(au) << ZSH) + QUO_W'(z_s2 >> 1);
		num_vz_s3 <= (QUO_W'(av) << ZSH) + QUO_W'(z_s2 >> 1);
		num_uv_s3 <= (QUO_W'(auv) << LSH) + QUO_W'(lden >> 1);
		num_ru_s3 <= ((QUO_W'(lam2_s2) + QUO_W'(uu_s2)) << LSH) + QUO_W'(lden >> 1);
		num_rv_s3 <= ((QUO_W'(lam2_s2) + QUO_W'(vv_s2)) << LSH) + QUO_W'(lden >> 1);
		side_s3.u  <= u_s2;
		side_s3.v  <= v_s2;
		side_s3.zz <= (z_s2 == '0);
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s3;
		for (int i = 1; i < QUO_W; i++) side_q[i] <= side_q[i-1];
	end

	pij_div #(.NUM_W(QUO_W), .DEN_W(DEPTH_W)) u_div_lz (
		.clk(clk), .num(num_lz_s3), .den(den_z_s3), .quo(q_lz));
	pij_div #(.NUM_W(QUO_W), .DEN_W(DEPTH_W)) u_div_uz (
		.clk(clk), .num(num_uz_s3), .den(den_z_s3), .quo(q_uz));
	pij_div #(.NUM_W(QUO_W), .DEN_W(DEPTH_W)) u_div_vz (
		.clk(clk), .num(num_vz_s3), .den(den_z_s3), .quo(q_vz));
	pij_div #(.NUM_W(QUO_W), .DEN_W(DEPTH_W)) u_div_uv (
		.clk(clk), .num(num_uv_s3), .den(den_l_s3), .quo(q_uv));
	pij_div #(.NUM_W(QUO_W), .DEN_W(DEPTH_W)) u_div_ru (
		.clk(clk), .num(num_ru_s3), .den(den_l_s3), .quo(q_ru));
	pij_div #(.NUM_W(QUO_W), .DEN_W(DEPTH_W)) u_div_rv (
		.clk(clk), .num(num_rv_s3), .den(den_l_s3), .quo(q_rv));

	// output stage: signs and zero depth saturation
	side_t            sd;
	logic [OUT_W-1:0] e_lz, e_uz, e_vz, e_uv, e_ru, e_rv;
	logic             uv_neg;
	always_comb begin
		sd     = side_q[QUO_W-1];
		e_lz   = OUT_W'(q_lz);
		e_uz   = OUT_W'(q_uz);
		e_vz   = OUT_W'(q_vz);
		e_uv   = OUT_W'(q_uv);
		e_ru   = OUT_W'(q_ru);
		e_rv   = OUT_W'(q_rv);
		uv_neg = sd.u[COORD_W-1] ^ sd.v[COORD_W-1];
	end

	always_ff @(posedge clk) begin
		depth_zero <= sd.zz;
		if (sd.zz) begin
			x_trans_x <= OUT_MIN;
			y_trans_y <= OUT_MIN;
			x_trans_z <= sd.u[COORD_W-1] ? OUT_MIN : ((sd.u == '0) ? '0 : OUT_MAX);
			y_trans_z <= sd.v[COORD_W-1] ? OUT_MIN : ((sd.v == '0) ? '0 : OUT_MAX);
		end else begin
			x_trans_x <= -e_lz;
			y_trans_y <= -e_lz;
			x_trans_z <= sd.u[COORD_W-1] ? -e_uz : e_uz;
			y_trans_z <= sd.v[COORD_W-1] ? -e_vz : e_vz;
		end
		x_rot_x <= uv_neg ? -e_uv : e_uv;
		y_rot_y <= uv_neg ? e_uv : -e_uv;
		x_rot_y <= -e_ru;
		y_rot_x <= -e_rv;
		x_rot_z <= OUT_W'(sd.v) <<< LSH;
		y_rot_z <= -(OUT_W'(sd.u) <<< LSH);
	end

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching command");
	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && depth_zero |-> x_trans_x == OUT_MIN && y_trans_y == OUT_MIN)
		else $error("zero depth not saturated");
	a_lz_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && !depth_zero |-> x_trans_x[OUT_W-1] || x_trans_x == '0)
		else $error("focal over depth term positive");
`endif

endmodule
